@@ hdl/ptum_pkg.sv @@
// ----------------------------------------------------------------------------
// ptum_pkg: shared types and constants of the PTS timeline mapper
// Field widths, mode codes, state machine states and the result and item types.
// ----------------------------------------------------------------------------
package ptum_pkg;

  localparam int NUM_TRACKS_DEF = 4;
  localparam int PTS_BITS_DEF   = 33;
  localparam int RAW_W          = 33;
  localparam int TIME_W         = 64;
  localparam int STEP_W         = 32;
  localparam int RATE_W         = 32;
  localparam int TRK_W          = 2;
  localparam logic [RAW_W-1:0] THRESH_RESET = 33'd90000;
  localparam logic [16:0] TICKS_PER_SEC = 17'd90000;

  typedef enum logic [1:0] {
    MODE_MAP     = 2'd0,
    MODE_OBSERVE = 2'd1,
    MODE_SEED    = 2'd2,
    MODE_PEEK    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              ok;
    logic [TIME_W-1:0] pts;
    logic [TIME_W-1:0] origin;
    logic              origin_valid;
    logic [RAW_W-1:0]  last_raw;
    logic              last_raw_valid;
    logic              discontinuity;
    logic              rebased;
    logic              derived;
  } result_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TRK_W-1:0]  track;
    logic              has_pts;
    logic [RAW_W-1:0]  raw_pts;
    logic [STEP_W-1:0] step_cnt;
    logic [RATE_W-1:0] unit_rate;
  } item_t;

endpackage

@@ hdl/ptum_if.sv @@
// ----------------------------------------------------------------------------
// ptum_if: valid/ready channel interfaces
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ptum_in_if;
  logic          valid;
  logic          ready;
  ptum_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptum_out_if;
  logic            valid;
  logic            ready;
  ptum_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptum_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ptum_pkg::RAW_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/ptum_divider.sv @@
// ----------------------------------------------------------------------------
// ptum_divider: bit-serial scale and divide
// Forms steps*90000+rem by shift-and-add, one multiplier bit per cycle, then
// divides by rate with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptum_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ptum_pkg::STEP_W-1:0]   steps,
  input  logic [ptum_pkg::RATE_W-1:0]   rate,
  input  logic [ptum_pkg::RATE_W-1:0]   rem_in,
  output logic                          done,
  output logic [ptum_pkg::TIME_W-1:0]   quot,
  output logic [ptum_pkg::RATE_W-1:0]   rem_out
);
  localparam int MW = 17;   // width of 90000
  localparam int NW = 64;   // dividend width
  localparam int CW = 7;
  localparam int RATE_W_L = ptum_pkg::RATE_W;

  logic [MW-1:0]   mplr_r, mplr_nxt;
  logic [NW-1:0]   acc_r, acc_nxt;
  logic [NW-1:0]   mcnd_r, mcnd_nxt;
  logic [RATE_W_L:0] rm_r, rm_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            mul_r, mul_nxt, busy_r, busy_nxt;
  logic [RATE_W_L:0] trial;

  always_comb begin
    mplr_nxt = mplr_r;
    acc_nxt  = acc_r;
    mcnd_nxt = mcnd_r;
    rm_nxt   = rm_r;
    cnt_nxt  = cnt_r;
    mul_nxt  = mul_r;
    busy_nxt = busy_r;
    done     = 1'b0;
    trial    = {rm_r[RATE_W_L-1:0], acc_r[NW-1]} - {1'b0, rate};
    if (start) begin
      // load multiplicand and seed the sum with the carried remainder
      mplr_nxt = ptum_pkg::TICKS_PER_SEC;
      mcnd_nxt = {{(NW-ptum_pkg::STEP_W){1'b0}}, steps};
      acc_nxt  = {{(NW-ptum_pkg::RATE_W){1'b0}}, rem_in};
      cnt_nxt  = CW'(MW);
      mul_nxt  = 1'b1;
      busy_nxt = 1'b1;
    end else if (busy_r && mul_r) begin
      // add one partial product per cycle
      if (mplr_r[0]) acc_nxt = acc_r + mcnd_r;
      mcnd_nxt = mcnd_r << 1;
      mplr_nxt = mplr_r >> 1;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        mul_nxt = 1'b0;
        cnt_nxt = CW'(NW);
        rm_nxt  = '0;
      end
    end else if (busy_r) begin
      // one restoring division step per cycle, quotient shifts into acc
      if (!trial[RATE_W_L]) begin
        rm_nxt  = {1'b0, trial[RATE_W_L-1:0]};
        acc_nxt = {acc_r[NW-2:0], 1'b1};
      end else begin
        rm_nxt  = {1'b0, rm_r[RATE_W_L-1:0]} << 1 | {{RATE_W_L{1'b0}}, acc_r[NW-1]};
        acc_nxt = {acc_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mul_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      mul_r  <= mul_nxt;
      cnt_r  <= cnt_nxt;
    end
    mplr_r <= mplr_nxt;
    acc_r  <= acc_nxt;
    mcnd_r <= mcnd_nxt;
    rm_r   <= rm_nxt;
  end

  assign quot    = acc_nxt;
  assign rem_out = rm_nxt[RATE_W_L-1:0];
endmodule

@@ hdl/pts_timeline_unwrap_mapper_top.sv @@
// ----------------------------------------------------------------------------
// pts_timeline_unwrap_mapper_top: 33-bit PTS unwrap and timeline mapper
// Unwraps PTS values, keeps per-track time, extrapolates from media rate.
//
//   channel | direction | payload
//   in_     | sink      | mode, track, has_pts, raw_pts, step_cnt, unit_rate
//   out_    | source    | ok, pts, origin, flags, last_raw
//   cfg_    | sink      | jump_threshold
//
// An item that needs extrapolation passes a decode state and then the divider
// (shift-and-add by 90000, then radix-2 division) before its result is
// offered; other items pass the decode and finish states instead.
// One item is in flight at a time; a result held by a stalled out_ready
// blocks the next item. Reset is synchronous, no sweep.
// ----------------------------------------------------------------------------
module pts_timeline_unwrap_mapper_top #(
  parameter int NUM_TRACKS = ptum_pkg::NUM_TRACKS_DEF,
  parameter int PTS_BITS   = ptum_pkg::PTS_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ptum_in_if.sink  in_ch,
  ptum_out_if.source out_ch,
  ptum_cfg_if.sink cfg_ch
);
  localparam int TW = ptum_pkg::TIME_W;
  localparam int RW = ptum_pkg::RAW_W;
  localparam int NT = 4;
  localparam logic [TW-1:0] MOD  = TW'(1) << PTS_BITS;
  localparam logic [TW-1:0] HALF = TW'(1) << (PTS_BITS - 1);
  localparam logic [TW-1:0] PMASK = MOD - TW'(1);

  ptum_pkg::state_t state_r, state_nxt;
  ptum_pkg::item_t  it_r;
  ptum_pkg::result_t res_r, res_nxt;
  logic [RW-1:0] thr_r;
  logic [TW-1:0] origin_r, lastu_r, lraw_r;
  logic          origin_k_r, lastu_k_r, lraw_k_r;
  logic [TW-1:0] ttime_r [NT];
  logic [31:0]   trem_r  [NT];
  logic [NT-1:0] tstart_r;

  logic          div_start, div_done;
  logic [TW-1:0] div_q, expect_t;
  logic [31:0]   div_rem;
  logic [1:0]    t;
  logic          good_track, started, need_div, upd;
  logic [TW-1:0] rawm, cand, u, diff, thr64;
  logic          disc, first;
  logic [TW-1:0] new_time;
  logic [31:0]   new_rem;
  logic          set_time, set_start, take;

  ptum_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .steps(it_r.step_cnt), .rate(it_r.unit_rate),
    .rem_in(trem_r[t]), .done(div_done), .quot(div_q), .rem_out(div_rem)
  );

  assign t          = it_r.track;
  assign good_track = ({30'd0, t} < 32'(NUM_TRACKS));
  assign started    = tstart_r[t];
  assign expect_t   = ttime_r[t] + div_q;
  assign thr64      = {{(TW-RW){1'b0}}, thr_r};
  assign rawm       = {{(TW-RW){1'b0}}, it_r.raw_pts} & PMASK;

  // unwrap against the last unwrapped timestamp
  always_comb begin
    cand = (lastu_r & ~PMASK) | rawm;
    if (cand < lastu_r && (lastu_r - cand) > HALF) cand = cand + MOD;
    else if (cand > lastu_r && (cand - lastu_r) > HALF && cand >= MOD) cand = cand - MOD;
    u = lastu_k_r ? cand : rawm;
  end

  // decide whether the item needs the divider
  always_comb begin
    need_div = 1'b0;
    case (ptum_pkg::mode_t'(it_r.mode))
      ptum_pkg::MODE_MAP:
        need_div = good_track && it_r.unit_rate != '0 && started
                   && !(it_r.has_pts && !origin_k_r);
      ptum_pkg::MODE_PEEK:
        need_div = good_track && it_r.unit_rate != '0 && started;
      default: need_div = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptum_pkg::ST_IDLE: if (in_ch.valid) state_nxt = ptum_pkg::ST_MUL;
      ptum_pkg::ST_MUL:  state_nxt = need_div ? ptum_pkg::ST_DIV : ptum_pkg::ST_FIN;
      ptum_pkg::ST_DIV:  if (div_done) state_nxt = ptum_pkg::ST_OUT;
      ptum_pkg::ST_FIN:  state_nxt = ptum_pkg::ST_OUT;
      ptum_pkg::ST_OUT:  if (out_ch.ready) state_nxt = ptum_pkg::ST_IDLE;
      default:           state_nxt = ptum_pkg::ST_IDLE;
    endcase
  end

  // handshakes and divider launch
  always_comb begin
    in_ch.ready  = (state_r == ptum_pkg::ST_IDLE);
    out_ch.valid = (state_r == ptum_pkg::ST_OUT);
    out_ch.data  = res_r;
    cfg_ch.ready = 1'b1;
    div_start    = (state_r == ptum_pkg::ST_MUL) && need_div;
    upd          = (state_r == ptum_pkg::ST_FIN) || (state_r == ptum_pkg::ST_DIV && div_done);
  end

  // compute result and state update
  always_comb begin
    res_nxt   = '0;
    disc      = 1'b0;
    first     = !origin_k_r;
    take      = 1'b0;
    set_time  = 1'b0;
    set_start = 1'b0;
    new_time  = '0;
    new_rem   = '0;
    diff      = (expect_t > u) ? expect_t - u : u - expect_t;
    res_nxt.ok = 1'b1;
    case (ptum_pkg::mode_t'(it_r.mode))
      ptum_pkg::MODE_MAP: begin
        if (!good_track || it_r.unit_rate == '0) res_nxt.ok = 1'b0;
        else if (it_r.has_pts) begin
          take = 1'b1;
          if (started && first) disc = 1'b1;
          else if (started && diff > thr64) disc = 1'b1;
          set_time = 1'b1; set_start = 1'b1; new_time = u;
          res_nxt.pts = u;
        end else begin
          set_time = 1'b1; set_start = 1'b1;
          if (started) begin
            new_time = expect_t; new_rem = div_rem;
          end else new_time = origin_k_r ? origin_r : '0;
          res_nxt.derived = 1'b1;
          res_nxt.pts = new_time;
        end
      end
      ptum_pkg::MODE_OBSERVE: begin
        if (!good_track || !it_r.has_pts) res_nxt.ok = 1'b0;
        else begin
          take = 1'b1;
          res_nxt.pts = ttime_r[t];
          diff = (ttime_r[t] > u) ? ttime_r[t] - u : u - ttime_r[t];
          if (first || !started || diff > thr64) begin
            set_time = 1'b1; set_start = 1'b1; new_time = u; res_nxt.pts = u;
            disc = started && (first || diff > thr64);
          end
        end
      end
      ptum_pkg::MODE_SEED: begin
        if (!it_r.has_pts) res_nxt.ok = 1'b0;
        else res_nxt.pts = origin_k_r ? origin_r : rawm;
      end
      default: begin
        if (!good_track || it_r.unit_rate == '0 || !started) res_nxt.ok = 1'b0;
        else begin
          res_nxt.pts = expect_t;
          res_nxt.derived = 1'b1;
        end
      end
    endcase
    if (res_nxt.ok) begin
      res_nxt.discontinuity = disc;
      res_nxt.rebased       = disc;
      if (origin_k_r) begin
        res_nxt.origin = origin_r; res_nxt.origin_valid = 1'b1;
      end else if (take || (it_r.mode == ptum_pkg::MODE_SEED)) begin
        res_nxt.origin = take ? u : rawm; res_nxt.origin_valid = 1'b1;
      end
      if (take) begin
        res_nxt.last_raw = rawm[RW-1:0]; res_nxt.last_raw_valid = 1'b1;
      end else if (lraw_k_r) begin
        res_nxt.last_raw = lraw_r[RW-1:0]; res_nxt.last_raw_valid = 1'b1;
      end
    end else begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ptum_pkg::ST_IDLE;
      thr_r      <= ptum_pkg::THRESH_RESET;
      origin_r   <= '0; origin_k_r <= 1'b0;
      lastu_r    <= '0; lastu_k_r  <= 1'b0;
      lraw_r     <= '0; lraw_k_r   <= 1'b0;
      tstart_r   <= '0;
      for (int i = 0; i < NT; i++) begin
        ttime_r[i] <= '0; trem_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) thr_r <= cfg_ch.data;
      if (upd) begin
        res_r <= res_nxt;
        if (res_nxt.ok) begin
          if (take) begin
            lastu_r <= u; lastu_k_r <= 1'b1;
            lraw_r <= rawm; lraw_k_r <= 1'b1;
          end
          if (!origin_k_r && res_nxt.origin_valid) begin
            origin_r <= res_nxt.origin; origin_k_r <= 1'b1;
          end
          if (set_time) begin
            ttime_r[t] <= new_time; trem_r[t] <= new_rem;
          end
          if (set_start) tstart_r[t] <= 1'b1;
        end
      end
    end
    if (state_r == ptum_pkg::ST_IDLE && in_ch.valid) it_r <= in_ch.data;
  end
endmodule
